### design/hbos_pkg.sv
// ----------------------------------------------------------------------------
// hbos_pkg: shared constants for the hierarchical bitmap ordered set
// Word geometry of the two-level bitmap, the key width and the command codes.
// ----------------------------------------------------------------------------
package hbos_pkg;

   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = 64;
   localparam int IDX_W      = $clog2(WORD_BITS);
   localparam int WORD_W     = $clog2(WORD_COUNT);
   localparam int KEY_W      = WORD_W + IDX_W;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_ERASE    = 3'd1,
      CMD_CONTAINS = 3'd2,
      CMD_NEXT_GE  = 3'd3,
      CMD_NEXT_GT  = 3'd4,
      CMD_PREV_LE  = 3'd5,
      CMD_PREV_LT  = 3'd6,
      CMD_CLEAR    = 3'd7
   } cmd_type;

endpackage

### design/hbos_find.sv
// ----------------------------------------------------------------------------
// hbos_find: shared priority encoder
// Finds the lowest or the highest set bit of a word and flags a nonzero word.
// ----------------------------------------------------------------------------
module hbos_find
   import hbos_pkg::*;
(
   input  logic [WORD_BITS-1:0] vec,
   input  logic                 dir_high,
   output logic [IDX_W-1:0]     idx,
   output logic                 any
);

   logic [WORD_BITS-1:0] oriented;
   logic [WORD_BITS-1:0] lowest;
   logic [IDX_W-1:0]     low_idx;

   // The highest bit is found as the lowest bit of the reversed word.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         oriented[i] = dir_high ? vec[WORD_BITS-1-i] : vec[i];
      end
   end

   assign lowest = oriented & (~oriented + WORD_BITS'(1));

   always_comb begin
      low_idx = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (((i >> b) & 1) == 1) begin
               low_idx[b] = low_idx[b] | lowest[i];
            end
         end
      end
   end

   assign idx = dir_high ? ~low_idx : low_idx;
   assign any = |vec;

endmodule

### design/hierarchical_bitmap_ordered_set_unit.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_ordered_set_unit: ordered set of 12-bit keys
// Insert, erase, contains, nearest-member searches and clear over a
// two-level bitmap of 64 leaf words and one summary word.
// ----------------------------------------------------------------------------
// One request is taken at a time, and the unit is not ready again until its
// response has been accepted. Every command first reads the leaf word of its
// key and acts on it; a search that finds nothing inside the key's own leaf
// word also scans the summary word, and one that finds another leaf word there
// fetches that word and takes its nearest set bit. The next request can be
// accepted in the cycle right after the response handshake. The sequence is
// shaped by the single read port of the leaf-word memory, whose read is
// registered, and by the one priority encoder that serves the leaf, the
// summary and the fetched word in turn. A summary bit doubles as the valid
// bit of its leaf word, so clear takes effect at once and needs no sweep of
// the memory.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_ordered_set_unit
   import hbos_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [11:0] key
   input  logic [2:0]  req_tuser,  // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [11:0] found_key
   output logic [1:0]  rsp_tuser   // [0] found, [1] set_empty
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_LEAF  = 7'b0000100,
      S_SUMM  = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_DESC  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   // Ones at positions at or above pos, or strictly above when skip is set.
   function automatic logic [WORD_BITS-1:0] mask_from(input logic [IDX_W-1:0] pos,
                                                      input logic skip);
      logic [IDX_W:0] amt;
      amt = {1'b0, pos} + (IDX_W+1)'(skip);
      return {WORD_BITS{1'b1}} << amt;
   endfunction

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic [IDX_W-1:0]        bit_ff, bit_in;
   logic [WORD_COUNT-1:0]   summary_ff, summary_in;
   logic [WORD_BITS-1:0]    rdata_ff;
   logic                    found_ff, found_in;
   logic [KEY_W-1:0]        found_key_ff, found_key_in;

   logic [WORD_BITS-1:0]    leaf_mem [WORD_COUNT];
   logic                    mem_we;
   logic [WORD_BITS-1:0]    mem_wdata;

   logic                    strict;
   logic                    down;
   logic [WORD_BITS-1:0]    leaf;
   logic [WORD_BITS-1:0]    bit_vec;
   logic [WORD_BITS-1:0]    leaf_after_erase;
   logic [WORD_BITS-1:0]    leaf_mask;
   logic [WORD_BITS-1:0]    summ_mask;
   logic [WORD_BITS-1:0]    find_vec;
   logic [IDX_W-1:0]        find_idx;
   logic                    find_any;

   assign strict = (cmd_ff == CMD_NEXT_GT) || (cmd_ff == CMD_PREV_LT);
   assign down   = (cmd_ff == CMD_PREV_LE) || (cmd_ff == CMD_PREV_LT);

   // A leaf word whose summary bit is clear is empty or has not been written
   // since the last clear, and reads as empty.
   assign leaf             = summary_ff[word_ff] ? rdata_ff : '0;
   assign bit_vec          = WORD_BITS'(1) << bit_ff;
   assign leaf_after_erase = leaf & ~bit_vec;
   assign leaf_mask = down ? ~mask_from(bit_ff, !strict) : mask_from(bit_ff, strict);
   assign summ_mask = down ? ~mask_from(word_ff, 1'b0) : mask_from(word_ff, 1'b1);

   always_comb begin
      unique case (state_ff)
         S_LEAF:  find_vec = leaf & leaf_mask;
         S_SUMM:  find_vec = summary_ff & summ_mask;
         default: find_vec = rdata_ff;
      endcase
   end

   hbos_find u_find (
      .vec      (find_vec),
      .dir_high (down),
      .idx      (find_idx),
      .any      (find_any)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         leaf_mem[word_ff] <= mem_wdata;
      end
      rdata_ff <= leaf_mem[word_ff];
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      summary_in   = summary_ff;
      found_in     = found_ff;
      found_key_in = found_key_ff;
      mem_we       = 1'b0;
      mem_wdata    = leaf | bit_vec;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser[2:0]);
               word_in  = req_tdata[KEY_W-1:IDX_W];
               bit_in   = req_tdata[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LEAF;
         end
         S_LEAF: begin
            found_in     = 1'b0;
            found_key_in = '0;
            state_in     = S_RESP;
            unique case (cmd_ff) inside
               CMD_INSERT: begin
                  mem_we              = 1'b1;
                  summary_in[word_ff] = 1'b1;
               end
               CMD_ERASE: begin
                  mem_we              = 1'b1;
                  mem_wdata           = leaf_after_erase;
                  summary_in[word_ff] = |leaf_after_erase;
               end
               CMD_CONTAINS: begin
                  found_in = |(leaf & bit_vec);
               end
               CMD_NEXT_GE, CMD_NEXT_GT, CMD_PREV_LE, CMD_PREV_LT: begin
                  if (find_any) begin
                     found_in     = 1'b1;
                     found_key_in = {word_ff, find_idx};
                  end else begin
                     state_in = S_SUMM;
                  end
               end
               CMD_CLEAR: begin
                  summary_in = '0;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SUMM: begin
            if (find_any) begin
               word_in  = find_idx;
               state_in = S_FETCH;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FETCH: begin
            state_in = S_DESC;
         end
         S_DESC: begin
            // The chosen word has its summary bit set, so it is nonempty.
            found_in     = 1'b1;
            found_key_in = {word_ff, find_idx};
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         summary_ff <= '0;
      end else begin
         state_ff   <= state_in;
         summary_ff <= summary_in;
      end
      cmd_ff       <= cmd_in;
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      found_ff     <= found_in;
      found_key_ff <= found_key_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {(16-KEY_W)'(0), found_key_ff};
   assign rsp_tuser  = {~|summary_ff, found_ff};

endmodule
